FILE: hw/rtl/lbpch_pkg.sv
// Shared types, codes and constants for the LBP code histogram block.
// Used by lbp_code_histogram; no dependencies of its own.
`timescale 1ns / 1ps

package lbpch_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int COUNT_BITS_DEF = 24;

	// Histogram geometry is fixed at one bin per 8-bit code.
	localparam int BIN_COUNT = 256;
	localparam int BIN_W     = 8;

	// Frame geometry limits and register reset values.
	localparam int                CFG_W_BITS   = 12;
	localparam int                CFG_H_BITS   = 13;
	localparam int                ROW_W        = 12;
	localparam logic [12:0]       MAX_HEIGHT   = 13'd4096;
	localparam logic [11:0]       WIDTH_RESET  = 12'd640;
	localparam logic [12:0]       HEIGHT_RESET = 13'd480;

	// Fixed output field widths.
	localparam int OUT_ROW_W   = 12;
	localparam int OUT_COL_W   = 11;
	localparam int OUT_COUNT_W = 24;

	// Input command codes.
	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// Result kinds.
	localparam logic KIND_CODE  = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	// Operation carried by an item through the pipeline.
	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_READ,
		OP_CLEAR
	} op_t;

	// 3x3 neighborhood, entry 4 is the center, row-major from top-left.
	typedef logic [8:0][7:0] window_t;

	// Per-item record carried by the pipeline stages.
	typedef struct packed {
		op_t                  op;
		logic [7:0]           px;
		logic [BIN_W-1:0]     bin;
		logic [7:0]           code;
		logic                 interior;
		logic                 border;
		logic [OUT_ROW_W-1:0] crow;
		logic [OUT_COL_W-1:0] ccol;
	} stage_t;

	// One bit per neighbor strictly greater than the center, top-left in bit 7,
	// then clockwise around to the left neighbor in bit 0.
	function automatic logic [7:0] lbp_code_f(input window_t w);
		logic [7:0] code;
		code[7] = w[0] > w[4];
		code[6] = w[1] > w[4];
		code[5] = w[2] > w[4];
		code[4] = w[5] > w[4];
		code[3] = w[8] > w[4];
		code[2] = w[7] > w[4];
		code[1] = w[6] > w[4];
		code[0] = w[3] > w[4];
		return code;
	endfunction

endpackage

FILE: hw/rtl/lbpch_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
`timescale 1ns / 1ps

module lbpch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage write and registered read; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lbp_code_histogram.sv
// Streaming 8-neighbor LBP code generator with a per-frame 256-bin histogram.
// Depends on lbpch_pkg and lbpch_ram.
//
// Usage:
// Items enter on the in channel (in_valid, in_stall, cmd, pixel, bin_index):
// a pixel in raster order, a histogram bin read, or a frame start that clears
// the histogram, the window and the position counters. Results leave on the
// out channel (out_valid, out_stall, kind and payload): one code result for
// each pixel that completes an interior center, one count result for each
// bin read. Frame size comes from the cfg write channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data), which is always ready.
// Throughput is one item per clock while the out channel does not stall. An
// accepted item passes stage 1, where its line store read completes, then
// stage 2, where its histogram read completes, then the output register.
// The histogram read-modify-write forwards the newest count to the following
// item, and bin 0 is a counter of its own so a border pixel and its code can
// both bump it in the same cycle. When the receiver stalls, the output register
// holds its result and the two internal stages keep filling; in_stall rises
// once both are occupied. Reset clears the histogram, positions and window
// at once, with no clearing pass; the line stores are never cleared.
`timescale 1ns / 1ps

module lbp_code_histogram
	import lbpch_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration writes.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [CFG_H_BITS-1:0]  cfg_data,
	// Input items.
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             cmd,
	input  logic [7:0]             pixel,
	input  logic [BIN_W-1:0]       bin_index,
	// Result items.
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [7:0]             lbp_code,
	output logic [OUT_ROW_W-1:0]   centre_row,
	output logic [OUT_COL_W-1:0]   centre_col,
	output logic [OUT_COUNT_W-1:0] bin_count
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW    = $clog2(MAX_WIDTH + 1);
	localparam int CW1   = COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration registers.
	logic [CFG_W_BITS-1:0] width_q;
	logic [CFG_H_BITS-1:0] height_q;

	// Position tracking at the input.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             done_q;

	// Pipeline stages.
	logic       valid_s1, valid_s2;
	stage_t     item_s1, item_s2, item_in, item_coded;
	logic [COL_W-1:0] col_s1;

	// Window, histogram side state and output register.
	window_t                 win_q, win_next;
	logic [COUNT_BITS-1:0]   bin0_q;
	logic [BIN_COUNT-1:0]    hvalid_q;
	logic                    fwd_en_q, rd_valid_q;
	logic [COUNT_BITS-1:0]   fwd_val_q;
	logic                    out_valid_q, out_kind_q;
	logic [7:0]              out_code_q;
	logic [OUT_ROW_W-1:0]    out_row_q;
	logic [OUT_COL_W-1:0]    out_col_q;
	logic [OUT_COUNT_W-1:0]  out_count_q;

	// Combinational signals.
	logic [EW-1:0]         eff_w;
	logic [CFG_H_BITS-1:0] eff_h;
	logic                  col_wrap, row_over, last_col, last_row;
	logic [COL_W-1:0]      c_cur;
	logic                  in_accept, px_go, s0_valid;
	logic                  s1_go, s1_free, s2_go, s2_free, s2_has_out, s2_wr, out_free;
	logic [15:0]           line_rdata;
	logic [7:0]            code_new;
	logic [BIN_W-1:0]      hraddr;
	logic [COUNT_BITS-1:0] hram_rdata, hist_cur, hist_new, hist_value;
	logic [1:0]            inc0;
	logic [CW1-1:0]        bin0_sum;
	logic [COUNT_BITS-1:0] bin0_next;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_W_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the frame size to the supported range.
	always_comb begin
		if (width_q < 12'd3) begin
			eff_w = EW'(3);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		if (height_q < 13'd3) begin
			eff_h = 13'd3;
		end else if (height_q > MAX_HEIGHT) begin
			eff_h = MAX_HEIGHT;
		end else begin
			eff_h = height_q;
		end
	end

	// Handshake: stages move when the next is free or moving, or have no output.
	assign out_free   = !out_valid_q || !out_stall;
	assign s2_has_out = (item_s2.op == OP_READ) || (item_s2.op == OP_PIXEL && item_s2.interior);
	assign s2_go      = valid_s2 && (!s2_has_out || out_free);
	assign s2_free    = !valid_s2 || s2_go;
	assign s1_go      = valid_s1 && s2_free;
	assign s1_free    = !valid_s1 || s1_go;
	assign in_stall   = !s1_free;
	assign in_accept  = in_valid && !in_stall;

	// Position of the arriving pixel and its border and interior flags.
	always_comb begin
		col_wrap = EW'(col_q) >= eff_w;
		c_cur    = col_wrap ? '0 : col_q;
		row_over = {1'b0, row_q} >= eff_h;
		last_col = EW'(c_cur) == eff_w - EW'(1);
		last_row = {1'b0, row_q} == eff_h - 13'd1;
		px_go    = in_accept && (cmd == CMD_PIXEL) && !done_q && !row_over;
		s0_valid = px_go || (in_accept && (cmd == CMD_READ || cmd == CMD_CLEAR));

		item_in.op       = (cmd == CMD_READ) ? OP_READ :
		                   (cmd == CMD_CLEAR) ? OP_CLEAR : OP_PIXEL;
		item_in.px       = pixel;
		item_in.bin      = bin_index;
		item_in.code     = '0;
		item_in.interior = (row_q > 12'd1) && (c_cur > COL_W'(1));
		item_in.border   = (row_q == '0) || last_row || (c_cur == '0) || last_col;
		item_in.crow     = row_q - 12'd1;
		item_in.ccol     = OUT_COL_W'(c_cur - 1'b1);
	end

	// Column and row counters and the end-of-frame flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			done_q <= 1'b0;
		end else if (in_accept) begin
			if (cmd == CMD_CLEAR) begin
				col_q  <= '0;
				row_q  <= '0;
				done_q <= 1'b0;
			end else if (cmd == CMD_PIXEL && !done_q) begin
				if (row_over) begin
					col_q  <= c_cur;
					done_q <= 1'b1;
				end else if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_q + 12'd1;
					end
				end else begin
					col_q <= COL_W'(c_cur + 1'b1);
				end
			end
		end
	end

	// Stage 1 register: the item waits here for its line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= s0_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && s0_valid) begin
			item_s1 <= item_in;
			col_s1  <= c_cur;
		end
	end

	// Both line stores in one RAM: upper byte two rows up, lower byte one row up.
	lbpch_ram #(
		.WIDTH(16),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_go && item_s1.op == OP_PIXEL),
		.waddr(col_s1),
		.wdata({line_rdata[7:0], item_s1.px}),
		.re   (px_go),
		.raddr(c_cur),
		.rdata(line_rdata)
	);

	// Window shift with the new column and the code of the new center.
	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = line_rdata[15:8];
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[5] = line_rdata[7:0];
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[8] = item_s1.px;
		code_new    = lbp_code_f(win_next);
		hraddr      = (item_s1.op == OP_READ) ? item_s1.bin : code_new;
		item_coded      = item_s1;
		item_coded.code = code_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_go) begin
			if (item_s1.op == OP_PIXEL) begin
				win_q <= win_next;
			end else if (item_s1.op == OP_CLEAR) begin
				win_q <= '0;
			end
		end
	end

	// Stage 2 register: the item waits here for its histogram read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			item_s2 <= item_coded;
		end
	end

	// Stage 2 count update; bins 1 and up live in the RAM.
	always_comb begin
		hist_cur = fwd_en_q ? fwd_val_q : (rd_valid_q ? hram_rdata : '0);
		hist_new = (hist_cur == CNT_MAX) ? hist_cur : hist_cur + 1'b1;
		s2_wr    = valid_s2 && item_s2.op == OP_PIXEL && item_s2.interior &&
		           item_s2.code != '0;

		inc0 = 2'd0;
		if (item_s2.op == OP_PIXEL) begin
			inc0 = 2'(item_s2.border) +
			       2'(item_s2.interior && item_s2.code == '0);
		end
		bin0_sum  = {1'b0, bin0_q} + CW1'(inc0);
		bin0_next = (bin0_sum > {1'b0, CNT_MAX}) ? CNT_MAX : bin0_sum[COUNT_BITS-1:0];

		hist_value = (item_s2.bin == '0) ? bin0_q : hist_cur;
	end

	lbpch_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BIN_COUNT)
	) u_hist_ram (
		.clk  (clk),
		.we   (s2_go && s2_wr),
		.waddr(item_s2.code),
		.wdata(hist_new),
		.re   (s1_go),
		.raddr(hraddr),
		.rdata(hram_rdata)
	);

	// Read bypass: a write or clear leaving stage 2 overrides the RAM data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q   <= 1'b0;
			fwd_val_q  <= '0;
			rd_valid_q <= 1'b0;
		end else if (s1_go) begin
			rd_valid_q <= hvalid_q[hraddr];
			if (s2_go && item_s2.op == OP_CLEAR) begin
				fwd_en_q  <= 1'b1;
				fwd_val_q <= '0;
			end else if (s2_go && s2_wr && item_s2.code == hraddr) begin
				fwd_en_q  <= 1'b1;
				fwd_val_q <= hist_new;
			end else begin
				fwd_en_q <= 1'b0;
			end
		end
	end

	// Bin valid bits and the bin 0 counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			bin0_q   <= '0;
		end else if (s2_go) begin
			if (item_s2.op == OP_CLEAR) begin
				hvalid_q <= '0;
				bin0_q   <= '0;
			end else if (item_s2.op == OP_PIXEL) begin
				bin0_q <= bin0_next;
				if (s2_wr) begin
					hvalid_q[item_s2.code] <= 1'b1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2 && s2_has_out;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2 && s2_has_out) begin
			if (item_s2.op == OP_READ) begin
				out_kind_q  <= KIND_COUNT;
				out_code_q  <= '0;
				out_row_q   <= '0;
				out_col_q   <= '0;
				out_count_q <= OUT_COUNT_W'(hist_value);
			end else begin
				out_kind_q  <= KIND_CODE;
				out_code_q  <= item_s2.code;
				out_row_q   <= item_s2.crow;
				out_col_q   <= item_s2.ccol;
				out_count_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = out_kind_q;
	assign lbp_code   = out_code_q;
	assign centre_row = out_row_q;
	assign centre_col = out_col_q;
	assign bin_count  = out_count_q;

	// A frame start leaving stage 2 empties the whole histogram.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_go && item_s2.op == OP_CLEAR) |=> (hvalid_q == '0 && bin0_q == '0))
		else $error("histogram not cleared after frame start");

	// Bin 0 only grows between frame starts.
	a_bin0_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(s2_go && item_s2.op == OP_CLEAR) |=> (bin0_q >= $past(bin0_q)))
		else $error("bin 0 count decreased without a frame start");

	// With both stages full behind a stalled result, input must stall.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && s2_has_out && out_valid_q && out_stall) |-> in_stall)
		else $error("input accepted with the pipeline full");

	// Pixels after the end of a frame are dropped at the input.
	a_overrun_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && cmd == CMD_PIXEL && done_q) |=> !valid_s1)
		else $error("pixel past the end of frame entered the pipeline");

endmodule
